// ----- hdl/lpbq_pkg.sv -----
package lpbq_pkg;

  localparam int SAMPLE_WIDTH = 32;

  localparam int IO_WIDTH   = 32;
  localparam int COEF_WIDTH = 32;
  localparam int GAIN_WIDTH = 31;

  // multiplier operand A is split into a 16-bit low half and a signed high half
  localparam int OPA_W = (SAMPLE_WIDTH > IO_WIDTH) ? SAMPLE_WIDTH : IO_WIDTH;
  localparam int MA_W  = OPA_W - 15;
  localparam int MP_W  = MA_W + COEF_WIDTH;
  localparam int ACC_W = OPA_W + COEF_WIDTH + 1;
  localparam int OUT_W = (SAMPLE_WIDTH < IO_WIDTH) ? SAMPLE_WIDTH : IO_WIDTH;

  localparam int COEF_SHIFT  = 30;
  localparam int PRIME_SHIFT = 16;

  localparam int N_PROD     = 5;
  localparam int STEP_W     = 4;
  localparam int MUL_END    = 2 * N_PROD;
  localparam int RUN_LAST   = 2 * N_PROD + 2;
  localparam int W_READY    = 6;
  localparam int PRIME_LAST = 3;

  typedef enum logic [2:0] {
    REG_B0   = 3'd0,
    REG_B1   = 3'd1,
    REG_B2   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4,
    REG_GAIN = 3'd5
  } reg_index_t;

  typedef enum logic [2:0] {
    PROD_A1 = 3'd0,
    PROD_A2 = 3'd1,
    PROD_B1 = 3'd2,
    PROD_B2 = 3'd3,
    PROD_B0 = 3'd4
  } prod_index_t;

  localparam logic OP_PRIME = 1'b1;

endpackage

// ----- hdl/second_order_lowpass_biquad.sv -----
// Direct Form II low-pass biquad, Q16.16 samples, Q2.30 coefficients. One sample
// is taken when s_tready is high; no new sample is taken until the result of the
// current one has been loaded into the output register, and a prime request
// (tuser bit set) adds a prime sequence first. A single 17x32 multiplier (wider for
// larger SAMPLE_WIDTH) forms each of the five products as a low half and then a
// high half. The user must write coefficients through cfg_we/cfg_index/cfg_data
// only while the block is idle, which the block does not enforce; the result waits
// in an output register, so the next sample is accepted while it is still pending.
module second_order_lowpass_biquad (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample_in
  input  logic [0:0]  s_tuser,   // [0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sample_out
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int SW    = lpbq_pkg::SAMPLE_WIDTH;
  localparam int OPA_W = lpbq_pkg::OPA_W;
  localparam int MA_W  = lpbq_pkg::MA_W;
  localparam int MP_W  = lpbq_pkg::MP_W;
  localparam int ACC_W = lpbq_pkg::ACC_W;
  localparam int OUT_W = lpbq_pkg::OUT_W;
  localparam int STEP_W = lpbq_pkg::STEP_W;
  localparam int W_READY_STEP = lpbq_pkg::W_READY;

  localparam logic signed [ACC_W-1:0] SW_MAX = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SW_MIN = ~SW_MAX;
  localparam logic signed [ACC_W-1:0] OW_MAX = {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] OW_MIN = ~OW_MAX;

  typedef enum logic [1:0] {IDLE, PRIME, RUN} state_t;

  function automatic logic signed [SW-1:0] sat_sw(input logic signed [ACC_W-1:0] v);
    if (v > SW_MAX) begin
      return SW_MAX[SW-1:0];
    end else if (v < SW_MIN) begin
      return SW_MIN[SW-1:0];
    end
    return v[SW-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_ow(input logic signed [ACC_W-1:0] v);
    if (v > OW_MAX) begin
      return OW_MAX[OUT_W-1:0];
    end else if (v < OW_MIN) begin
      return OW_MIN[OUT_W-1:0];
    end
    return v[OUT_W-1:0];
  endfunction

  state_t                    state;
  logic [STEP_W-1:0]         step;
  logic                      opcode;
  logic signed [31:0]        sample;
  logic signed [31:0]        coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic [30:0]               inverse_dc_gain;
  logic signed [SW-1:0]      delay_one, delay_two, w0;
  logic signed [MP_W-1:0]    mreg;
  logic signed [ACC_W-1:0]   prod, wacc, yacc;

  logic signed [OPA_W-1:0]   opa;
  logic signed [31:0]        mb;
  logic signed [MA_W-1:0]    ma;
  logic signed [MP_W-1:0]    mul_out;
  logic signed [ACC_W-1:0]   prod_sum, term;
  logic signed [OUT_W-1:0]   y_sat;
  logic                      mul_en, sum_en, acc_en, finish, load_out;
  lpbq_pkg::prod_index_t     pidx;

  assign s_tready = (state == IDLE);

  always_comb begin
    pidx = lpbq_pkg::prod_index_t'(step[STEP_W-1:1]);
    opa  = OPA_W'(sample);
    mb   = signed'({1'b0, inverse_dc_gain});
    if (state == RUN) begin
      case (pidx)
        lpbq_pkg::PROD_A1: begin opa = OPA_W'(delay_one); mb = coef_a1; end
        lpbq_pkg::PROD_A2: begin opa = OPA_W'(delay_two); mb = coef_a2; end
        lpbq_pkg::PROD_B1: begin opa = OPA_W'(delay_one); mb = coef_b1; end
        lpbq_pkg::PROD_B2: begin opa = OPA_W'(delay_two); mb = coef_b2; end
        default:           begin opa = OPA_W'(w0);        mb = coef_b0; end
      endcase
    end
  end

  assign ma = step[0] ? signed'({opa[OPA_W-1], opa[OPA_W-1:16]})
                      : signed'({{(MA_W-16){1'b0}}, opa[15:0]});
  assign mul_out  = ma * mb;
  assign prod_sum = prod + (ACC_W'(mreg) <<< 16);
  assign term     = (state == PRIME) ? (prod >>> lpbq_pkg::PRIME_SHIFT)
                                     : (prod >>> lpbq_pkg::COEF_SHIFT);
  assign y_sat    = sat_ow(yacc);

  assign mul_en = (state == PRIME && step < STEP_W'(2)) ||
                  (state == RUN && step < STEP_W'(lpbq_pkg::MUL_END));
  assign sum_en = (state == PRIME && step == STEP_W'(2)) ||
                  (state == RUN && !step[0] && step >= STEP_W'(2) &&
                   step <= STEP_W'(lpbq_pkg::MUL_END));
  assign acc_en = state == RUN && step[0] && step >= STEP_W'(3) &&
                  step <= STEP_W'(lpbq_pkg::MUL_END + 1);
  assign finish = state == RUN && step == STEP_W'(lpbq_pkg::RUN_LAST);
  assign load_out = finish && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0         <= '0;
      coef_b1         <= '0;
      coef_b2         <= '0;
      coef_a1         <= '0;
      coef_a2         <= '0;
      inverse_dc_gain <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpbq_pkg::REG_B0:   coef_b0 <= cfg_data;
        lpbq_pkg::REG_B1:   coef_b1 <= cfg_data;
        lpbq_pkg::REG_B2:   coef_b2 <= cfg_data;
        lpbq_pkg::REG_A1:   coef_a1 <= cfg_data;
        lpbq_pkg::REG_A2:   coef_a2 <= cfg_data;
        lpbq_pkg::REG_GAIN: inverse_dc_gain <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      mreg <= mul_out;
      if (step[0]) begin
        prod <= ACC_W'(mreg);
      end
    end
    if (sum_en) begin
      prod <= prod_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      step      <= '0;
      m_tvalid  <= 1'b0;
      delay_one <= '0;
      delay_two <= '0;
    end else begin
      m_tvalid <= load_out || (m_tvalid && !m_tready);
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            sample <= s_tdata;
            opcode <= s_tuser[0];
            wacc   <= ACC_W'(signed'(s_tdata));
            yacc   <= '0;
            step   <= '0;
            state  <= (s_tuser[0] == lpbq_pkg::OP_PRIME) ? PRIME : RUN;
          end
        end
        PRIME: begin
          if (step == STEP_W'(lpbq_pkg::PRIME_LAST)) begin
            delay_one <= sat_sw(term);
            delay_two <= sat_sw(term);
            step      <= '0;
            state     <= RUN;
          end else begin
            step <= step + 1'b1;
          end
        end
        RUN: begin
          if (acc_en) begin
            if (step < STEP_W'(W_READY_STEP)) begin
              wacc <= wacc - term;
            end else begin
              yacc <= yacc + term;
            end
          end
          if (step == STEP_W'(W_READY_STEP)) begin
            w0 <= (wacc > SW_MAX || wacc < SW_MIN) ? sat_sw(ACC_W'(sample)) : wacc[SW-1:0];
          end
          if (finish) begin
            if (load_out) begin
              m_tdata   <= 32'(y_sat);
              delay_two <= delay_one;
              delay_one <= w0;
              state     <= IDLE;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted a second sample while busy");

  a_prime_bounded: assert property (@(posedge clk) disable iff (rst)
    state == PRIME |-> step <= STEP_W'(lpbq_pkg::PRIME_LAST))
    else $error("prime sequence overran");

  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(finish))
    else $error("result raised outside the final step");

  a_prime_enters_run: assert property (@(posedge clk) disable iff (rst)
    state == PRIME && step == STEP_W'(lpbq_pkg::PRIME_LAST) |=> state == RUN && step == '0)
    else $error("prime did not hand over to filter run");

  a_opcode_path: assert property (@(posedge clk) disable iff (rst)
    state == PRIME |-> opcode == lpbq_pkg::OP_PRIME)
    else $error("prime entered without prime opcode");

endmodule
